// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("frame parser assertion failed");

// Boolean condition must never be seen outside reset.
`define RFP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("frame parser forbidden condition seen");

`endif

// ===== sv/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Types, codes and helpers shared by the reader frame parser modules.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam logic [7:0]  START_BYTE      = 8'hAA;
  localparam logic [7:0]  END_BYTE        = 8'hDD;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd1000;
  localparam logic [15:0] IDLE_TICK_RESET = 16'd100;

  localparam logic [1:0] MSG_TYPE_FIRST = 2'd1;
  localparam logic [1:0] MSG_TYPE_LAST  = 2'd2;

  localparam logic [7:0] CMD_ERROR_REPLY = 8'hFF;
  localparam logic [7:0] CMD_MODULE_INFO = 8'h03;
  localparam logic [7:0] CMD_CARD_POLL   = 8'h22;
  localparam logic [7:0] ERR_COMMAND     = 8'h17;
  localparam logic [7:0] ERR_READ_FAIL   = 8'h09;
  localparam logic [7:0] ERR_NO_CARD     = 8'h15;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_MAX_LEN    = 1'b0,
    CFG_IDLE_TICKS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_CMD,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CSUM,
    PH_END
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABORT   = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ABORT_NONE     = 2'd0,
    ABORT_BAD_TYPE = 2'd1,
    ABORT_TOO_LONG = 2'd2,
    ABORT_TIMEOUT  = 2'd3
  } abort_e;

  typedef enum logic [2:0] {
    CLS_CMD_ERROR     = 3'd0,
    CLS_READ_FAIL     = 3'd1,
    CLS_NO_CARD       = 3'd2,
    CLS_OTHER_ERROR   = 3'd3,
    CLS_MODULE_INFO   = 3'd4,
    CLS_CARD_DETECTED = 3'd5,
    CLS_UNHANDLED     = 3'd6
  } class_e;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  msg_type;
    logic [7:0]  command;
    logic [15:0] length;
    logic [15:0] count;
    logic [7:0]  sum;
    logic [7:0]  rx_sum;
    logic [23:0] head;
    logic [15:0] idle;
  } frame_state_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   payload_byte;
    logic [15:0]  payload_index;
    logic [1:0]   message_type;
    logic [7:0]   command_code;
    logic [15:0]  payload_length;
    logic         checksum_ok;
    logic         end_marker_ok;
    abort_e       abort_reason;
    class_e       message_class;
    logic [7:0]   first_payload_byte;
    logic [15:0]  protocol_control;
  } result_t;

  function automatic class_e classify(input logic [7:0] cmd, input logic [7:0] first);
    class_e cls;
    cls = CLS_UNHANDLED;
    case (cmd)
      CMD_ERROR_REPLY: begin
        case (first)
          ERR_COMMAND:   cls = CLS_CMD_ERROR;
          ERR_READ_FAIL: cls = CLS_READ_FAIL;
          ERR_NO_CARD:   cls = CLS_NO_CARD;
          default:       cls = CLS_OTHER_ERROR;
        endcase
      end
      CMD_MODULE_INFO: cls = CLS_MODULE_INFO;
      CMD_CARD_POLL:   cls = CLS_CARD_DETECTED;
      default:         cls = CLS_UNHANDLED;
    endcase
    return cls;
  endfunction

endpackage

// ===== sv/rfp_step.sv =====
// ----------------------------------------------------------------------------
// rfp_step
// One parser step: next frame state and optional result for one item.
// ----------------------------------------------------------------------------
module rfp_step import rfp_pkg::*; (
  input  frame_state_t state_i,
  input  logic         opcode_i,
  input  logic [7:0]   rx_byte_i,
  input  logic [15:0]  max_len_i,
  input  logic [15:0]  idle_ticks_i,
  output frame_state_t state_o,
  output logic         result_valid_o,
  output result_t      result_o
);

  logic        is_tick;
  logic [15:0] idle_inc;
  logic [15:0] idle_limit;
  logic        timeout_hit;
  logic [15:0] len_full;
  logic        bad_type;
  logic        too_long;
  logic [15:0] count_inc;
  logic [7:0]  first_byte;
  phase_e      phase_d;

  assign is_tick     = (opcode_i == OP_TICK);
  assign idle_inc    = (state_i.idle == 16'hFFFF) ? state_i.idle : state_i.idle + 16'd1;
  // A limit of zero behaves like one tick.
  assign idle_limit  = (idle_ticks_i == 16'd0) ? 16'd1 : idle_ticks_i;
  assign timeout_hit = is_tick && (state_i.phase != PH_HUNT) && (idle_inc >= idle_limit);
  assign len_full    = {state_i.length[15:8], rx_byte_i};
  assign bad_type    = (rx_byte_i == 8'd0) || (rx_byte_i > 8'd2);
  assign too_long    = (len_full > max_len_i);
  assign count_inc   = state_i.count + 16'd1;
  assign first_byte  = state_i.head[23:16];

  // Phase sequencing.
  always_comb begin
    phase_d = state_i.phase;
    if (is_tick) begin
      if (timeout_hit) begin
        phase_d = PH_HUNT;
      end
    end else begin
      case (state_i.phase)
        PH_HUNT:    phase_d = (rx_byte_i == START_BYTE) ? PH_TYPE : PH_HUNT;
        PH_TYPE:    phase_d = bad_type ? PH_HUNT : PH_CMD;
        PH_CMD:     phase_d = PH_LEN_HI;
        PH_LEN_HI:  phase_d = PH_LEN_LO;
        PH_LEN_LO: begin
          if (too_long) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = (len_full == 16'd0) ? PH_CSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: phase_d = (count_inc >= state_i.length) ? PH_CSUM : PH_PAYLOAD;
        PH_CSUM:    phase_d = PH_END;
        PH_END:     phase_d = PH_HUNT;
        default:    phase_d = PH_HUNT;
      endcase
    end
  end

  // Held header, sums and result.
  always_comb begin
    state_o        = state_i;
    result_valid_o = 1'b0;
    result_o       = '0;
    if (is_tick) begin
      if (state_i.phase != PH_HUNT) begin
        state_o.idle = idle_inc;
      end
      if (timeout_hit) begin
        state_o.idle          = 16'd0;
        result_valid_o        = 1'b1;
        result_o.kind         = KIND_ABORT;
        result_o.abort_reason = ABORT_TIMEOUT;
      end
    end else begin
      state_o.idle = 16'd0;
      case (state_i.phase)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) begin
            state_o.msg_type = 2'd0;
            state_o.command  = 8'd0;
            state_o.length   = 16'd0;
            state_o.count    = 16'd0;
            state_o.sum      = 8'd0;
            state_o.rx_sum   = 8'd0;
            state_o.head     = 24'd0;
          end
        end
        PH_TYPE: begin
          if (bad_type) begin
            result_valid_o        = 1'b1;
            result_o.kind         = KIND_ABORT;
            result_o.abort_reason = ABORT_BAD_TYPE;
          end else begin
            state_o.msg_type = rx_byte_i[1:0];
            state_o.sum      = rx_byte_i;
          end
        end
        PH_CMD: begin
          state_o.command = rx_byte_i;
          state_o.sum     = state_i.sum + rx_byte_i;
        end
        PH_LEN_HI: begin
          state_o.length = {rx_byte_i, 8'd0};
          state_o.sum    = state_i.sum + rx_byte_i;
        end
        PH_LEN_LO: begin
          state_o.length = len_full;
          state_o.sum    = state_i.sum + rx_byte_i;
          if (too_long) begin
            result_valid_o        = 1'b1;
            result_o.kind         = KIND_ABORT;
            result_o.abort_reason = ABORT_TOO_LONG;
          end
        end
        PH_PAYLOAD: begin
          result_valid_o         = 1'b1;
          result_o.kind          = KIND_PAYLOAD;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = state_i.count;
          case (state_i.count)
            16'd0:   state_o.head[23:16] = rx_byte_i;
            16'd1:   state_o.head[15:8]  = rx_byte_i;
            16'd2:   state_o.head[7:0]   = rx_byte_i;
            default: state_o.head        = state_i.head;
          endcase
          state_o.sum   = state_i.sum + rx_byte_i;
          state_o.count = count_inc;
        end
        PH_CSUM: begin
          state_o.rx_sum = rx_byte_i;
        end
        PH_END: begin
          result_valid_o              = 1'b1;
          result_o.kind               = KIND_DONE;
          result_o.message_type       = state_i.msg_type;
          result_o.command_code       = state_i.command;
          result_o.payload_length     = state_i.length;
          result_o.checksum_ok        = (state_i.sum == state_i.rx_sum);
          result_o.end_marker_ok      = (rx_byte_i == END_BYTE);
          result_o.message_class      = classify(state_i.command, first_byte);
          result_o.first_payload_byte = first_byte;
          result_o.protocol_control   = state_i.head[15:0];
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
    state_o.phase = phase_d;
  end

endmodule

// ===== sv/rfid_reader_frame_parser.sv =====
// ----------------------------------------------------------------------------
// rfid_reader_frame_parser
// Byte-serial reader frame parser with payload streaming and frame reports.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per transfer: a received byte
// (opcode_i = 0) or one idle tick (opcode_i = 1). The output channel gives
// at most one result per item: a payload byte with its index, a frame
// completion report, or an abort. Both channels transfer when valid is high
// and stall is low. Configuration writes use cfg_valid_i/cfg_ready_o with a
// register index (0 max payload length, 1 idle timeout); cfg_ready_o is
// always high, and writes to other indexes are dropped.
// Throughput is one item per cycle while the receiver does not stall. An
// item goes into an input register, is parsed from there, and its result
// is written to the output register, where the receiver can take it.
// When the receiver stalls, the waiting result holds; the input register
// still takes one more item, and items that give no result keep being
// parsed. Reset clears the parser back to hunting for a start byte and
// loads the register defaults (1000 bytes, 100 ticks).
module rfid_reader_frame_parser import rfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [1:0]  message_type_o,
  output logic [7:0]  command_code_o,
  output logic [15:0] payload_length_o,
  output logic        checksum_ok_o,
  output logic        end_marker_ok_o,
  output logic [1:0]  abort_reason_o,
  output logic [2:0]  message_class_o,
  output logic [7:0]  first_payload_byte_o,
  output logic [15:0] protocol_control_o
);

  logic [15:0]  max_len_q;
  logic [15:0]  idle_ticks_q;
  logic         in_valid_q;
  logic         in_op_q;
  logic [7:0]   in_byte_q;
  frame_state_t state_q;
  frame_state_t state_d;
  logic         res_valid;
  result_t      res;
  logic         out_valid_q;
  result_t      out_q;
  logic         step_go;
  logic         in_xfer;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= MAX_LEN_RESET;
      idle_ticks_q <= IDLE_TICK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == {1'b0, CFG_MAX_LEN}) begin
        max_len_q <= cfg_data_i;
      end else if (cfg_index_i == {1'b0, CFG_IDLE_TICKS}) begin
        idle_ticks_q <= cfg_data_i;
      end
    end
  end

  rfp_step u_step (
    .state_i       (state_q),
    .opcode_i      (in_op_q),
    .rx_byte_i     (in_byte_q),
    .max_len_i     (max_len_q),
    .idle_ticks_i  (idle_ticks_q),
    .state_o       (state_d),
    .result_valid_o(res_valid),
    .result_o      (res)
  );

  // The held item is parsed unless it has a result and the output is blocked.
  assign step_go    = in_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_go;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (step_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q   <= opcode_i;
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = out_q.kind;
  assign payload_byte_o       = out_q.payload_byte;
  assign payload_index_o      = out_q.payload_index;
  assign message_type_o       = out_q.message_type;
  assign command_code_o       = out_q.command_code;
  assign payload_length_o     = out_q.payload_length;
  assign checksum_ok_o        = out_q.checksum_ok;
  assign end_marker_ok_o      = out_q.end_marker_ok;
  assign abort_reason_o       = out_q.abort_reason;
  assign message_class_o      = out_q.message_class;
  assign first_payload_byte_o = out_q.first_payload_byte;
  assign protocol_control_o   = out_q.protocol_control;

endmodule

// ===== sv/rfp_checker.sv =====
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level checks of the frame parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfp_checker import rfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [15:0] payload_index_o,
  input logic [1:0]  message_type_o,
  input logic [7:0]  command_code_o,
  input logic [15:0] payload_length_o,
  input logic        checksum_ok_o,
  input logic        end_marker_ok_o,
  input logic [1:0]  abort_reason_o,
  input logic [2:0]  message_class_o,
  input logic [7:0]  first_payload_byte_o,
  input logic [15:0] protocol_control_o
);

  logic is_abort;
  logic is_done;
  logic is_payload;

  assign is_abort   = out_valid_o && (result_kind_o == KIND_ABORT);
  assign is_done    = out_valid_o && (result_kind_o == KIND_DONE);
  assign is_payload = out_valid_o && (result_kind_o == KIND_PAYLOAD);

  // A result held by the receiver must not change.
  `RFP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) && $stable(payload_index_o) && $stable(abort_reason_o) && $stable(payload_length_o))

  // An abort always carries its reason, and other results never do.
  `RFP_ASSERT_NEVER(a_abort_reason, clk_i, rst_ni, is_abort && (abort_reason_o == ABORT_NONE))
  `RFP_ASSERT_NEVER(a_stray_reason, clk_i, rst_ni, (is_done || is_payload) && (abort_reason_o != ABORT_NONE))

  // A completed frame passed the type check, so its type is one of the two.
  `RFP_ASSERT(a_done_type, clk_i, rst_ni, is_done |-> (message_type_o == MSG_TYPE_FIRST) || (message_type_o == MSG_TYPE_LAST))

  // A payload byte result carries none of the frame report fields.
  `RFP_ASSERT_NEVER(a_payload_clean, clk_i, rst_ni, is_payload && ((payload_length_o != 16'd0) || checksum_ok_o || end_marker_ok_o))

endmodule

bind rfid_reader_frame_parser rfp_checker u_rfp_checker (.*);
